### src/blm_pkg.sv
// Shared types, constants and double-precision compare helpers for the line minimizer.
package blm_pkg;

  localparam int ITER_W = 8;
  localparam int SIG_W  = 110;
  localparam int EXP_W  = 13;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL, FOP_DIV} fop_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

  localparam logic [1:0] ST_QUERY = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;
  localparam logic [1:0] ST_STRAY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM  = 3'd4;

  localparam logic [63:0] D_ZERO   = 64'h0000000000000000;
  localparam logic [63:0] D_HALF   = 64'h3FE0000000000000;
  localparam logic [63:0] D_TWO    = 64'h4000000000000000;
  localparam logic [63:0] D_GOLD   = 64'h3FD87221858BC59C;
  localparam logic [63:0] D_EPS    = 64'h3DDB7CDFD9D7BDBB;
  localparam logic [63:0] D_QNAN   = 64'hFFF8000000000000;

  function automatic logic f_isnan(input logic [63:0] v);
    return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
  endfunction

  function automatic logic [63:0] f_mag(input logic [63:0] v);
    return {1'b0, v[62:0]};
  endfunction

  // total-order key; both zeros map to the same key
  function automatic logic [63:0] f_key(input logic [63:0] v);
    logic [63:0] z;
    z = (v[62:0] == 63'd0) ? 64'd0 : v;
    return z[63] ? ~z : {1'b1, z[62:0]};
  endfunction

  function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
    return !f_isnan(a) && !f_isnan(b) && (f_key(a) < f_key(b));
  endfunction

  function automatic logic f_le(input logic [63:0] a, input logic [63:0] b);
    return !f_isnan(a) && !f_isnan(b) && (f_key(a) <= f_key(b));
  endfunction

  function automatic logic f_eq(input logic [63:0] a, input logic [63:0] b);
    return !f_isnan(a) && !f_isnan(b) && (f_key(a) == f_key(b));
  endfunction

  function automatic logic f_gt(input logic [63:0] a, input logic [63:0] b);
    return f_lt(b, a);
  endfunction

  function automatic logic f_ge(input logic [63:0] a, input logic [63:0] b);
    return f_le(b, a);
  endfunction

  function automatic logic [63:0] f_sign_of(input logic [63:0] m, input logic [63:0] s);
    return f_ge(s, D_ZERO) ? {1'b0, m[62:0]} : {1'b1, m[62:0]};
  endfunction

endpackage

### src/blm_fpu.sv
// Multi-cycle IEEE double add/sub/mul/div unit, round to nearest even.
module blm_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  blm_pkg::fpu_req_t req_i,
  output blm_pkg::fpu_rsp_t rsp_o
);
  import blm_pkg::*;

  localparam int IB = SIG_W - 2;

  typedef enum logic [2:0] {F_IDLE, F_ADD, F_PRE, F_MUL, F_DIV, F_NORM, F_RND} fst_t;

  fst_t                    fst_r;
  logic [SIG_W-1:0]        sig_r, bsh_r;
  logic [52:0]             ma_r, mb_r;
  logic signed [EXP_W-1:0] ea_r, eb_r, e_r;
  logic                    rs_r, sub_r;
  logic [6:0]              cnt_r;
  logic [54:0]             rem_r;
  logic [63:0]             res_r;
  logic                    done_r;

  function automatic logic [SIG_W-1:0] shr_st(input logic [SIG_W-1:0] v, input logic [11:0] d);
    logic [SIG_W-1:0] m;
    logic [SIG_W-1:0] r;
    m = '0;
    if (d >= 12'(SIG_W)) begin
      r = {{(SIG_W-1){1'b0}}, |v};
    end else begin
      m = ({{(SIG_W-1){1'b0}}, 1'b1} << d) - {{(SIG_W-1){1'b0}}, 1'b1};
      r = v >> d;
      r[0] = r[0] | (|(v & m));
    end
    return r;
  endfunction

  // operand decode
  logic sa, sb, sbe, sr;
  logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [52:0] mfa, mfb;
  logic signed [EXP_W-1:0] eea, eeb, ediff;
  logic a_big;
  logic spec;
  logic [63:0] spec_res;

  always_comb begin
    sa  = req_i.a[63];
    sb  = req_i.b[63];
    sbe = (req_i.op == FOP_SUB) ? ~sb : sb;
    sr  = sa ^ sb;
    nan_a  = f_isnan(req_i.a);
    nan_b  = f_isnan(req_i.b);
    inf_a  = (req_i.a[62:52] == 11'h7FF) && (req_i.a[51:0] == 52'd0);
    inf_b  = (req_i.b[62:52] == 11'h7FF) && (req_i.b[51:0] == 52'd0);
    zero_a = (req_i.a[62:0] == 63'd0);
    zero_b = (req_i.b[62:0] == 63'd0);
    mfa = {req_i.a[62:52] != 11'd0, req_i.a[51:0]};
    mfb = {req_i.b[62:52] != 11'd0, req_i.b[51:0]};
    eea = (req_i.a[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, req_i.a[62:52]});
    eeb = (req_i.b[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, req_i.b[62:52]});
    a_big = req_i.a[62:0] >= req_i.b[62:0];
    ediff = a_big ? (eea - eeb) : (eeb - eea);
    spec = 1'b1;
    spec_res = D_QNAN;
    if (nan_a) begin
      spec_res = req_i.a | 64'h0008000000000000;
    end else if (nan_b) begin
      spec_res = req_i.b | 64'h0008000000000000;
    end else begin
      case (req_i.op)
        FOP_ADD, FOP_SUB: begin
          if (inf_a && inf_b) spec_res = (sa != sbe) ? D_QNAN : req_i.a;
          else if (inf_a) spec_res = req_i.a;
          else if (inf_b) spec_res = {sbe, req_i.b[62:0]};
          else if (zero_a && zero_b) spec_res = {sa & sbe, 63'd0};
          else spec = 1'b0;
        end
        FOP_MUL: begin
          if ((inf_a && zero_b) || (zero_a && inf_b)) spec_res = D_QNAN;
          else if (inf_a || inf_b) spec_res = {sr, 11'h7FF, 52'd0};
          else if (zero_a || zero_b) spec_res = {sr, 63'd0};
          else spec = 1'b0;
        end
        FOP_DIV: begin
          if ((inf_a && inf_b) || (zero_a && zero_b)) spec_res = D_QNAN;
          else if (inf_a) spec_res = {sr, 11'h7FF, 52'd0};
          else if (inf_b) spec_res = {sr, 63'd0};
          else if (zero_b) spec_res = {sr, 11'h7FF, 52'd0};
          else if (zero_a) spec_res = {sr, 63'd0};
          else spec = 1'b0;
        end
        default: spec = 1'b0;
      endcase
    end
  end

  // datapath helpers
  logic [SIG_W-1:0] sum, acc_n, sig_dn;
  logic             qbit;
  logic [54:0]      rem_n;
  logic [52:0]      mant;
  logic [53:0]      m54;
  logic             grd, stk, inc;
  logic signed [EXP_W-1:0] e2;
  logic [52:0]      fr;

  always_comb begin
    sum   = sub_r ? (sig_r - bsh_r) : (sig_r + bsh_r);
    acc_n = (sig_r << 1) + (mb_r[52] ? {{(SIG_W-53){1'b0}}, ma_r} : '0);
    qbit  = rem_r >= {2'b00, mb_r};
    rem_n = qbit ? (rem_r - {2'b00, mb_r}) : rem_r;
    sig_dn = {1'b0, sig_r[SIG_W-1:2], sig_r[1] | sig_r[0]};
    mant = sig_r[IB -: 53];
    grd  = sig_r[IB-53];
    stk  = |sig_r[IB-54:0];
    inc  = grd & (stk | mant[0]);
    m54  = {1'b0, mant} + {53'd0, inc};
    if (m54[53]) begin
      e2 = e_r + 13'sd1;
      fr = m54[53:1];
    end else begin
      e2 = e_r;
      fr = m54[52:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r  <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (fst_r)
        F_IDLE: begin
          if (req_i.start) begin
            if (spec) begin
              res_r  <= spec_res;
              done_r <= 1'b1;
            end else begin
              case (req_i.op)
                FOP_ADD, FOP_SUB: begin
                  sub_r <= (sa != sbe);
                  rs_r  <= a_big ? sa : sbe;
                  e_r   <= a_big ? eea : eeb;
                  sig_r <= {1'b0, (a_big ? mfa : mfb), {(SIG_W-54){1'b0}}};
                  bsh_r <= shr_st({1'b0, (a_big ? mfb : mfa), {(SIG_W-54){1'b0}}},
                                  ediff[11:0]);
                  fst_r <= F_ADD;
                end
                FOP_MUL: begin
                  rs_r  <= sr;
                  ma_r  <= mfa;
                  mb_r  <= mfb;
                  sig_r <= '0;
                  cnt_r <= 7'd53;
                  e_r   <= eea + eeb - 13'sd1023;
                  fst_r <= F_MUL;
                end
                default: begin
                  rs_r  <= sr;
                  ma_r  <= mfa;
                  mb_r  <= mfb;
                  ea_r  <= eea;
                  eb_r  <= eeb;
                  fst_r <= F_PRE;
                end
              endcase
            end
          end
        end
        F_ADD: begin
          sig_r <= sum;
          if (sum == '0) rs_r <= 1'b0;
          fst_r <= F_NORM;
        end
        F_PRE: begin
          // bring subnormal divider operands to a leading one
          if (!ma_r[52]) begin
            ma_r <= ma_r << 1;
            ea_r <= ea_r - 13'sd1;
          end
          if (!mb_r[52]) begin
            mb_r <= mb_r << 1;
            eb_r <= eb_r - 13'sd1;
          end
          if (ma_r[52] && mb_r[52]) begin
            e_r   <= ea_r - eb_r + 13'sd1023;
            rem_r <= {2'b00, ma_r};
            sig_r <= '0;
            cnt_r <= 7'(SIG_W - 1);
            fst_r <= F_DIV;
          end
        end
        F_MUL: begin
          mb_r  <= mb_r << 1;
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            sig_r <= acc_n << 4;
            fst_r <= F_NORM;
          end else begin
            sig_r <= acc_n;
          end
        end
        F_DIV: begin
          cnt_r <= cnt_r - 7'd1;
          rem_r <= rem_n << 1;
          if (cnt_r == 7'd1) begin
            sig_r <= {sig_r[SIG_W-2:0], qbit} | {{(SIG_W-1){1'b0}}, rem_n != 55'd0};
            fst_r <= F_NORM;
          end else begin
            sig_r <= {sig_r[SIG_W-2:0], qbit};
          end
        end
        F_NORM: begin
          if (sig_r == '0) begin
            fst_r <= F_RND;
          end else if (sig_r[SIG_W-1]) begin
            sig_r <= sig_dn;
            e_r   <= e_r + 13'sd1;
          end else if (e_r < -13'sd115) begin
            // far below the smallest subnormal: only a sticky bit survives
            sig_r <= {{(SIG_W-1){1'b0}}, 1'b1};
            e_r   <= 13'sd1;
          end else if (e_r < 13'sd1) begin
            sig_r <= sig_dn;
            e_r   <= e_r + 13'sd1;
          end else if (!sig_r[IB] && (e_r > 13'sd1)) begin
            sig_r <= sig_r << 1;
            e_r   <= e_r - 13'sd1;
          end else begin
            fst_r <= F_RND;
          end
        end
        F_RND: begin
          if (e2 >= 13'sd2047) res_r <= {rs_r, 11'h7FF, 52'd0};
          else res_r <= {rs_r, (fr[52] ? e2[10:0] : 11'd0), fr[51:0]};
          done_r <= 1'b1;
          fst_r  <= F_IDLE;
        end
        default: fst_r <= F_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.res  = res_r;

endmodule

### src/brent_line_minimizer.sv
// Top level: Brent line search sequencer around a shared double-precision unit.
// Usage: write the bracket ends, start point, tolerance and evaluation limit
// through the cfg_ port while idle. A word on the input channel with func 0
// starts a search; the result word carries the first query point. Feed back
// the cost at each query point as a word with func 1; each answer yields one
// result word: a new query (status 0), converged (1), limit reached (2), or
// an unexpected cost word (3) that changes nothing.
// A start or stray word goes through S_EMIT into the output register; a cost
// word that hits the evaluation limit goes through S_UPD (except the first
// cost word), S_ADV and S_EMIT. Other cost words run the update on the shared
// FP unit, which does every add, multiply and divide in turn: an add aligns
// and sums, a multiply runs a shift-add loop, a divide brings its operands to
// a leading one and runs a restoring loop, and each then normalizes shift by
// shift and rounds; zero, infinite or NaN operands skip the datapath. Deep
// cancellation adds normalize shifts. One word is in work at a time; in_stall
// is high from acceptance until its result is placed in the output register.
// The output register holds a result while out_stall is high; the next input
// word can still be taken and worked on meanwhile.
// Reset (rst_n low, synchronous) clears the search state, loads the register
// defaults (evaluation limit 100) and empties the output register.
module brent_line_minimizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [63:0] in_cost_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_query_point,
  output logic [63:0] out_best_point,
  output logic [63:0] out_best_cost,
  output logic [7:0]  out_iterations,
  input  logic        cfg_we,
  input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import blm_pkg::*;

  localparam int CW = (ITER_W > 8) ? ITER_W : 8;

  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_TRIAL, PH_DONE} phase_t;

  typedef enum logic [5:0] {
    S_IDLE, S_UPD, S_ADV,
    S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8, S_A9, S_CONV,
    S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_B8, S_B9, S_B10, S_B11, S_FIX,
    S_B12, S_B13, S_B14, S_B15, S_B16, S_B17, S_TEST,
    S_G1, S_G2, S_P1, S_P2, S_P3, S_P4, S_PT, S_P5, S_P6, S_FIN, S_EMIT
  } state_t;

  state_t      state_r, op_nxt;
  phase_t      phase_r;
  logic        issued_r;

  logic [63:0] cfg_low_r, cfg_mid_r, cfg_high_r, cfg_tol_r;
  logic [7:0]  cfg_lim_r;

  logic [63:0] low_r, high_r, bx_r, sx_r, psx_r, bf_r, sf_r, psf_r;
  logic [63:0] sbl_r, last_r, pend_r, fu_r;
  logic [ITER_W-1:0] cnt_r;
  logic [63:0] mid_r, tol1_r, tol2_r, ta_r, tb_r, tc_r, rr_r, qq_r, pp_r, old_r;
  logic [1:0]  st_r;
  logic [63:0] qry_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [63:0] out_query_r, out_best_pt_r, out_best_cost_r;
  logic [7:0]  out_iter_r;

  fpu_req_t    fpu_req;
  fpu_rsp_t    fpu_rsp;
  logic        is_op;
  fop_t        op;
  logic [63:0] opa, opb;

  logic        accept;
  logic [CW-1:0] cnt_ext, lim_ext, cap_ext, lim_eff;
  logic        bad_fit;

  blm_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (fpu_req),
    .rsp_o (fpu_rsp)
  );

  assign accept  = in_valid && !in_stall;
  assign cnt_ext = CW'(cnt_r);
  assign lim_ext = CW'(cfg_lim_r);
  assign cap_ext = CW'({ITER_W{1'b1}});
  assign lim_eff = (lim_ext > cap_ext) ? cap_ext : lim_ext;
  assign bad_fit = f_eq(qq_r, D_ZERO) || f_ge(f_mag(pp_r), f_mag(ta_r)) ||
                   f_le(pp_r, tb_r) || f_ge(pp_r, tc_r);

  // operation issued by each arithmetic step
  always_comb begin
    is_op  = 1'b1;
    op     = FOP_ADD;
    opa    = D_ZERO;
    opb    = D_ZERO;
    op_nxt = S_IDLE;
    case (state_r)
      S_A1:  begin op = FOP_ADD; opa = low_r;  opb = high_r;        op_nxt = S_A2;  end
      S_A2:  begin op = FOP_MUL; opa = D_HALF; opb = ta_r;          op_nxt = S_A3;  end
      S_A3:  begin op = FOP_MUL; opa = cfg_tol_r; opb = f_mag(bx_r); op_nxt = S_A4; end
      S_A4:  begin op = FOP_ADD; opa = ta_r;   opb = D_EPS;         op_nxt = S_A5;  end
      S_A5:  begin op = FOP_MUL; opa = D_TWO;  opb = tol1_r;        op_nxt = S_A6;  end
      S_A6:  begin op = FOP_SUB; opa = bx_r;   opb = mid_r;         op_nxt = S_A7;  end
      S_A7:  begin op = FOP_SUB; opa = high_r; opb = low_r;         op_nxt = S_A8;  end
      S_A8:  begin op = FOP_MUL; opa = D_HALF; opb = tb_r;          op_nxt = S_A9;  end
      S_A9:  begin op = FOP_SUB; opa = tol2_r; opb = tb_r;          op_nxt = S_CONV; end
      S_B1:  begin op = FOP_SUB; opa = bx_r;   opb = sx_r;          op_nxt = S_B2;  end
      S_B2:  begin op = FOP_SUB; opa = bf_r;   opb = psf_r;         op_nxt = S_B3;  end
      S_B3:  begin op = FOP_MUL; opa = ta_r;   opb = tb_r;          op_nxt = S_B4;  end
      S_B4:  begin op = FOP_SUB; opa = bx_r;   opb = psx_r;         op_nxt = S_B5;  end
      S_B5:  begin op = FOP_SUB; opa = bf_r;   opb = sf_r;          op_nxt = S_B6;  end
      S_B6:  begin op = FOP_MUL; opa = tb_r;   opb = tc_r;          op_nxt = S_B7;  end
      S_B7:  begin op = FOP_MUL; opa = tb_r;   opb = qq_r;          op_nxt = S_B8;  end
      S_B8:  begin op = FOP_MUL; opa = ta_r;   opb = rr_r;          op_nxt = S_B9;  end
      S_B9:  begin op = FOP_SUB; opa = tc_r;   opb = ta_r;          op_nxt = S_B10; end
      S_B10: begin op = FOP_SUB; opa = qq_r;   opb = rr_r;          op_nxt = S_B11; end
      S_B11: begin op = FOP_MUL; opa = D_TWO;  opb = ta_r;          op_nxt = S_FIX; end
      S_B12: begin op = FOP_MUL; opa = D_HALF; opb = qq_r;          op_nxt = S_B13; end
      S_B13: begin op = FOP_MUL; opa = ta_r;   opb = old_r;         op_nxt = S_B14; end
      S_B14: begin op = FOP_SUB; opa = low_r;  opb = bx_r;          op_nxt = S_B15; end
      S_B15: begin op = FOP_MUL; opa = qq_r;   opb = tb_r;          op_nxt = S_B16; end
      S_B16: begin op = FOP_SUB; opa = high_r; opb = bx_r;          op_nxt = S_B17; end
      S_B17: begin op = FOP_MUL; opa = qq_r;   opb = tc_r;          op_nxt = S_TEST; end
      S_G1:  begin
        op = FOP_SUB; opa = f_ge(bx_r, mid_r) ? low_r : high_r; opb = bx_r; op_nxt = S_G2;
      end
      S_G2:  begin op = FOP_MUL; opa = D_GOLD; opb = sbl_r;         op_nxt = S_FIN; end
      S_P1:  begin op = FOP_DIV; opa = pp_r;   opb = qq_r;          op_nxt = S_P2;  end
      S_P2:  begin op = FOP_ADD; opa = bx_r;   opb = last_r;        op_nxt = S_P3;  end
      S_P3:  begin op = FOP_SUB; opa = ta_r;   opb = low_r;         op_nxt = S_P4;  end
      S_P4:  begin op = FOP_SUB; opa = high_r; opb = ta_r;          op_nxt = S_PT;  end
      S_P5:  begin op = FOP_SUB; opa = mid_r;  opb = bx_r;          op_nxt = S_P6;  end
      S_FIN: begin
        op = FOP_ADD; opa = bx_r;
        opb = f_ge(f_mag(last_r), tol1_r) ? last_r : f_sign_of(tol1_r, last_r);
        op_nxt = S_EMIT;
      end
      default: is_op = 1'b0;
    endcase
    fpu_req.start = is_op && !issued_r;
    fpu_req.op    = op;
    fpu_req.a     = opa;
    fpu_req.b     = opb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_low_r   <= '0;
      cfg_mid_r   <= '0;
      cfg_high_r  <= '0;
      cfg_tol_r   <= '0;
      cfg_lim_r   <= 8'd100;
      low_r  <= '0; high_r <= '0; bx_r <= '0; sx_r <= '0; psx_r <= '0;
      bf_r   <= '0; sf_r   <= '0; psf_r <= '0;
      sbl_r  <= '0; last_r <= '0; pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOW:  cfg_low_r  <= cfg_data;
          CFG_MID:  cfg_mid_r  <= cfg_data;
          CFG_HIGH: cfg_high_r <= cfg_data;
          CFG_TOL:  cfg_tol_r  <= cfg_data;
          CFG_LIM:  cfg_lim_r  <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && (state_r != S_EMIT)) out_valid_r <= 1'b0;

      if (is_op) begin
        if (!issued_r) begin
          issued_r <= 1'b1;
        end else if (fpu_rsp.done) begin
          issued_r <= 1'b0;
          state_r  <= op_nxt;
          case (state_r)
            S_A1, S_A3, S_A6, S_B1, S_B8, S_B10, S_B12, S_B13, S_P2, S_P5:
              ta_r <= fpu_rsp.res;
            S_A7, S_A8, S_A9, S_B2, S_B4, S_B14, S_B15, S_P3: tb_r <= fpu_rsp.res;
            S_B5, S_B7, S_B16, S_B17, S_P4: tc_r <= fpu_rsp.res;
            S_A2:  mid_r  <= fpu_rsp.res;
            S_A4:  tol1_r <= fpu_rsp.res;
            S_A5:  tol2_r <= fpu_rsp.res;
            S_B3:  rr_r   <= fpu_rsp.res;
            S_B6, S_B11: qq_r <= fpu_rsp.res;
            S_B9:  pp_r   <= fpu_rsp.res;
            S_G1:  sbl_r  <= fpu_rsp.res;
            S_G2, S_P1: last_r <= fpu_rsp.res;
            S_FIN: begin
              pend_r  <= fpu_rsp.res;
              qry_r   <= fpu_rsp.res;
              st_r    <= ST_QUERY;
              phase_r <= PH_TRIAL;
            end
            default: ;
          endcase
        end
      end else begin
        case (state_r)
          S_IDLE: begin
            if (accept) begin
              if (!in_func) begin
                low_r  <= f_lt(cfg_low_r, cfg_high_r) ? cfg_low_r : cfg_high_r;
                high_r <= f_gt(cfg_low_r, cfg_high_r) ? cfg_low_r : cfg_high_r;
                bx_r   <= cfg_mid_r;
                sx_r   <= cfg_mid_r;
                psx_r  <= cfg_mid_r;
                bf_r   <= D_ZERO;
                sf_r   <= D_ZERO;
                psf_r  <= D_ZERO;
                sbl_r  <= D_ZERO;
                last_r <= D_ZERO;
                pend_r <= cfg_mid_r;
                cnt_r  <= '0;
                phase_r <= PH_FIRST;
                st_r    <= ST_QUERY;
                qry_r   <= cfg_mid_r;
                state_r <= S_EMIT;
              end else begin
                fu_r <= in_cost_value;
                case (phase_r)
                  PH_FIRST: begin
                    bf_r  <= in_cost_value;
                    sf_r  <= in_cost_value;
                    psf_r <= in_cost_value;
                    state_r <= S_ADV;
                  end
                  PH_TRIAL: state_r <= S_UPD;
                  default: begin
                    st_r    <= ST_STRAY;
                    qry_r   <= D_ZERO;
                    state_r <= S_EMIT;
                  end
                endcase
              end
            end
          end
          S_UPD: begin
            if (cnt_r != {ITER_W{1'b1}}) cnt_r <= cnt_r + 1'b1;
            if (f_le(fu_r, bf_r)) begin
              if (f_ge(pend_r, bx_r)) low_r <= bx_r;
              else high_r <= bx_r;
              psx_r <= sx_r;
              sx_r  <= bx_r;
              bx_r  <= pend_r;
              psf_r <= sf_r;
              sf_r  <= bf_r;
              bf_r  <= fu_r;
            end else begin
              if (f_lt(pend_r, bx_r)) low_r <= pend_r;
              else high_r <= pend_r;
              if (f_le(fu_r, sf_r) || f_eq(sx_r, bx_r)) begin
                psx_r <= sx_r;
                sx_r  <= pend_r;
                psf_r <= sf_r;
                sf_r  <= fu_r;
              end else if (f_le(fu_r, psf_r) || f_eq(psx_r, bx_r) || f_eq(psx_r, sx_r)) begin
                psx_r <= pend_r;
                psf_r <= fu_r;
              end
            end
            state_r <= S_ADV;
          end
          S_ADV: begin
            if (cnt_ext >= lim_eff) begin
              phase_r <= PH_DONE;
              st_r    <= ST_LIMIT;
              qry_r   <= D_ZERO;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_A1;
            end
          end
          S_CONV: begin
            if (f_le(f_mag(ta_r), tb_r)) begin
              phase_r <= PH_DONE;
              st_r    <= ST_CONV;
              qry_r   <= D_ZERO;
              state_r <= S_EMIT;
            end else if (f_gt(f_mag(sbl_r), tol1_r)) begin
              state_r <= S_B1;
            end else begin
              state_r <= S_G1;
            end
          end
          S_FIX: begin
            if (f_gt(qq_r, D_ZERO)) pp_r <= {~pp_r[63], pp_r[62:0]};
            qq_r    <= f_mag(qq_r);
            old_r   <= sbl_r;
            sbl_r   <= last_r;
            state_r <= S_B12;
          end
          S_TEST: state_r <= bad_fit ? S_G1 : S_P1;
          S_PT: begin
            if (f_lt(tb_r, tol2_r) || f_lt(tc_r, tol2_r)) state_r <= S_P5;
            else state_r <= S_FIN;
          end
          S_P6: begin
            last_r  <= f_sign_of(tol1_r, ta_r);
            state_r <= S_FIN;
          end
          S_EMIT: begin
            if (!out_valid_r || !out_stall) begin
              out_valid_r     <= 1'b1;
              out_status_r    <= st_r;
              out_query_r     <= qry_r;
              out_best_pt_r   <= bx_r;
              out_best_cost_r <= bf_r;
              out_iter_r      <= cnt_ext[7:0];
              state_r         <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_query_point = out_query_r;
  assign out_best_point  = out_best_pt_r;
  assign out_best_cost   = out_best_cost_r;
  assign out_iterations  = out_iter_r;

endmodule
